### rtl/core/assert_macros.svh
// assertion macros for the rsi core modules
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge outside reset
`define WRSI_ASSERT_ALWAYS(lbl, ck, rn, expr, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define WRSI_ASSERT_IMPLIES(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/core/wrsi_pkg.sv
// constants and controller/datapath command and status types for the rsi core
// no dependencies
package wrsi_pkg;

    localparam int AVG_BITS        = 48;
    localparam int AVG_FRAC        = 8;
    localparam int WIN_BITS        = 8;
    localparam int CNT_BITS        = 9;
    localparam int RSI_BITS        = 23;
    // full scale 6553600 = 25 * 2^18
    localparam int RSI_SHIFT       = 18;
    localparam int RSI_FACTOR_BITS = 5;

    localparam logic [AVG_BITS-1:0] AVG_MAX   = {AVG_BITS{1'b1}};
    localparam logic [WIN_BITS-1:0] WIN_RESET = 8'd14;
    localparam logic [RSI_BITS-1:0] RSI_FULL  = 23'd6553600;

    typedef struct packed {
        logic accept;
        logic warm_step;
        logic seed_go;
        logic seed_load;
        logic mul;
        logic upd_go;
        logic upd_load;
        logic rsi_go;
        logic rsi_load;
        logic out_load;
    } wrsi_cmd_t;

    typedef struct packed {
        logic warmed;
        logic seed_now;
        logic win_done;
        logic rsi_done;
    } wrsi_sts_t;

endpackage

### rtl/core/wrsi_if.sv
// valid/ready channel interfaces for price requests, results and configuration
// depends on wrsi_pkg
interface wrsi_price_if #(
    parameter int PRICE_BITS = 32
) ();
    logic                  valid;
    logic                  ready;
    logic [PRICE_BITS-1:0] price;

    modport source (output valid, output price, input ready);
    modport sink   (input valid, input price, output ready);
endinterface

interface wrsi_result_if import wrsi_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [RSI_BITS-1:0] rsi_value;
    logic                rsi_valid;

    modport source (output valid, output rsi_value, output rsi_valid, input ready);
    modport sink   (input valid, input rsi_value, input rsi_valid, output ready);
endinterface

interface wrsi_cfg_if import wrsi_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [WIN_BITS-1:0] window_length;

    modport source (output valid, output window_length, input ready);
    modport sink   (input valid, input window_length, output ready);
endinterface

### rtl/core/wrsi_div.sv
// restoring divider, one quotient bit per cycle
// depends on nothing; caller keeps divisor stable while busy and the quotient fits QW bits
module wrsi_div #(
    parameter int DW = 56,
    parameter int VW = 8,
    parameter int QW = 48
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [QW-1:0] quotient,
    output logic [VW-1:0] remainder
);

    localparam int CW = $clog2(QW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [QW-1:0] low_reg, low_next;
    logic [VW:0]   trial;
    logic          fits;

    always_comb
    begin
        trial     = {rem_reg, low_reg[QW-1]};
        fits      = trial >= {1'b0, divisor};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(QW);
            rem_next  = VW'(dividend[DW-1:QW]);
            low_next  = dividend[QW-1:0];
        end
        else if (busy_reg)
        begin
            rem_next = fits ? VW'(trial - {1'b0, divisor}) : VW'(trial);
            low_next = {low_reg[QW-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
    end

    assign done      = done_reg;
    assign quotient  = low_reg;
    assign remainder = rem_reg;

endmodule

### rtl/core/wrsi_datapath.sv
// rsi datapath: window register, running sums, averages, dividers and result registers
// depends on wrsi_pkg and wrsi_div; sequenced by wrsi_ctrl through wrsi_cmd_t
module wrsi_datapath import wrsi_pkg::*; #(
    parameter int PRICE_BITS = 32,
    parameter int WINDOW_MAX = 255
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [PRICE_BITS-1:0] price,
    input  logic                  cfg_wr,
    input  logic [WIN_BITS-1:0]   cfg_data,
    input  wrsi_cmd_t             cmd,
    output wrsi_sts_t             sts,
    output logic [RSI_BITS-1:0]   rsi_value,
    output logic                  rsi_valid
);

    localparam int MW   = PRICE_BITS + AVG_FRAC;
    localparam int QB   = (MW > AVG_BITS) ? MW : AVG_BITS;
    localparam int WDW  = QB + WIN_BITS;
    localparam int PW   = AVG_BITS + WIN_BITS;
    localparam int MULB = AVG_BITS + RSI_FACTOR_BITS;
    localparam int NUMB = MULB + RSI_SHIFT;
    localparam int DENB = AVG_BITS + 1;
    localparam int WTOP = (1 << WIN_BITS) - 1;
    localparam int WMAX_EFF = (WINDOW_MAX > WTOP) ? WTOP : WINDOW_MAX;
    localparam logic [WIN_BITS-1:0] WMAX = WIN_BITS'(WMAX_EFF);

    function automatic logic [AVG_BITS-1:0] sat_avg(input logic [QB:0] v);
        logic [AVG_BITS-1:0] r;
        r = (v > (QB+1)'(AVG_MAX)) ? AVG_MAX : v[AVG_BITS-1:0];
        return r;
    endfunction

    logic [WIN_BITS-1:0]   window_reg;
    logic [WIN_BITS-1:0]   w_raw, w_eff, w_less1;
    logic [PRICE_BITS-1:0] prev_reg, price_reg;
    logic [CNT_BITS-1:0]   count_reg;
    logic                  warmed_reg;
    logic [AVG_BITS-1:0]   gain_reg, loss_reg;
    logic [MW-1:0]         up_reg, down_reg, up_next, down_next;
    logic [PW-1:0]         prod_g_reg, prod_l_reg;
    logic [DENB-1:0]       den_reg, den_next;
    logic [RSI_BITS-1:0]   res_value_reg, out_value_reg;
    logic                  res_valid_reg, out_valid_reg;
    logic                  has_prev;
    logic [AVG_BITS-1:0]   gain_sum, loss_sum, loss_floor;
    logic [WDW:0]          upd_g, upd_l;
    logic [WDW-1:0]        div_g_in, div_l_in;
    logic                  win_start;
    logic                  done_g, done_l, done_r;
    logic [QB-1:0]         q_g, q_l;
    logic [AVG_BITS-1:0]   q_g_sat, q_l_sat;
    logic [MULB-1:0]       g_ext, g_mul;
    logic [NUMB-1:0]       num;
    logic [RSI_BITS-1:0]   q_r, rsi_final;
    logic [DENB-1:0]       r_r;
    logic                  round_up;
    logic [RSI_BITS:0]     q_round;

    // effective window: zero acts as one, clamp at the maximum
    always_comb
    begin
        w_raw   = (window_reg == '0) ? WIN_BITS'(1) : window_reg;
        w_eff   = (w_raw > WMAX) ? WMAX : w_raw;
        w_less1 = w_eff - WIN_BITS'(1);
    end

    // price change of the incoming request, scaled to the average format
    always_comb
    begin
        has_prev  = (count_reg != '0) || warmed_reg;
        up_next   = '0;
        down_next = '0;
        if (has_prev && (price > prev_reg))
            up_next = {price - prev_reg, {AVG_FRAC{1'b0}}};
        else if (has_prev)
            down_next = {prev_reg - price, {AVG_FRAC{1'b0}}};
    end

    always_comb
    begin
        gain_sum = sat_avg((QB+1)'(gain_reg) + (QB+1)'(up_reg));
        loss_sum = sat_avg((QB+1)'(loss_reg) + (QB+1)'(down_reg));
        upd_g    = (WDW+1)'(prod_g_reg) + (WDW+1)'(up_reg);
        upd_l    = (WDW+1)'(prod_l_reg) + (WDW+1)'(down_reg);
        win_start = cmd.seed_go | cmd.upd_go;
        div_g_in = cmd.upd_go ? upd_g[WDW-1:0] : WDW'(gain_reg);
        div_l_in = cmd.upd_go ? upd_l[WDW-1:0] : WDW'(loss_reg);
        q_g_sat  = sat_avg((QB+1)'(q_g));
        q_l_sat  = sat_avg((QB+1)'(q_l));
    end

    // rsi = full * g / (g + max(l, 1)), full = 25 * 2^18
    always_comb
    begin
        loss_floor = (loss_reg == '0) ? AVG_BITS'(1) : loss_reg;
        den_next   = DENB'(gain_reg) + DENB'(loss_floor);
        g_ext      = MULB'(gain_reg);
        g_mul      = (g_ext << 4) + (g_ext << 3) + g_ext;
        num        = {g_mul, {RSI_SHIFT{1'b0}}};
        round_up   = {r_r, 1'b0} >= {1'b0, den_reg};
        q_round    = (RSI_BITS+1)'(q_r) + (RSI_BITS+1)'(round_up);
        rsi_final  = (q_round > (RSI_BITS+1)'(RSI_FULL)) ? RSI_FULL : q_round[RSI_BITS-1:0];
    end

    wrsi_div #(.DW(WDW), .VW(WIN_BITS), .QW(QB)) u_div_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (win_start),
        .dividend  (div_g_in),
        .divisor   (w_eff),
        .done      (done_g),
        .quotient  (q_g),
        .remainder ()
    );

    wrsi_div #(.DW(WDW), .VW(WIN_BITS), .QW(QB)) u_div_loss (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (win_start),
        .dividend  (div_l_in),
        .divisor   (w_eff),
        .done      (done_l),
        .quotient  (q_l),
        .remainder ()
    );

    wrsi_div #(.DW(NUMB), .VW(DENB), .QW(RSI_BITS)) u_div_rsi (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.rsi_go),
        .dividend  (num),
        .divisor   (den_reg),
        .done      (done_r),
        .quotient  (q_r),
        .remainder (r_r)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_reg <= WIN_RESET;
        else if (cfg_wr)
            window_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= '0;
            count_reg  <= '0;
            warmed_reg <= 1'b0;
            gain_reg   <= '0;
            loss_reg   <= '0;
        end
        else
        begin
            if (cmd.warm_step)
            begin
                if (count_reg != '0)
                begin
                    gain_reg <= gain_sum;
                    loss_reg <= loss_sum;
                end
                prev_reg  <= price_reg;
                count_reg <= count_reg + CNT_BITS'(1);
            end
            if (cmd.seed_load)
            begin
                gain_reg   <= q_g_sat;
                loss_reg   <= (q_l_sat == '0) ? AVG_BITS'(1) : q_l_sat;
                warmed_reg <= 1'b1;
            end
            if (cmd.upd_load)
            begin
                gain_reg <= q_g_sat;
                loss_reg <= q_l_sat;
                prev_reg <= price_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            price_reg <= price;
            up_reg    <= up_next;
            down_reg  <= down_next;
        end
        if (cmd.mul)
        begin
            prod_g_reg <= PW'(gain_reg) * PW'(w_less1);
            prod_l_reg <= PW'(loss_reg) * PW'(w_less1);
        end
        if (cmd.rsi_go)
            den_reg <= den_next;
        if (cmd.warm_step)
        begin
            res_value_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        if (cmd.rsi_load)
        begin
            res_value_reg <= rsi_final;
            res_valid_reg <= 1'b1;
        end
        if (cmd.out_load)
        begin
            out_value_reg <= res_value_reg;
            out_valid_reg <= res_valid_reg;
        end
    end

    assign sts.warmed   = warmed_reg;
    assign sts.seed_now = count_reg >= CNT_BITS'(w_eff);
    assign sts.win_done = done_g & done_l;
    assign sts.rsi_done = done_r;

    assign rsi_value = out_value_reg;
    assign rsi_valid = out_valid_reg;

endmodule

### rtl/core/wrsi_ctrl.sv
// rsi controller: sequences warm-up, seeding, average update and rsi division
// depends on wrsi_pkg and assert_macros.svh; drives wrsi_datapath through wrsi_cmd_t
`include "assert_macros.svh"

module wrsi_ctrl import wrsi_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  wrsi_sts_t sts,
    output wrsi_cmd_t cmd
);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_PREP      = 9'b000000010,
        S_SEED      = 9'b000000100,
        S_SEED_WAIT = 9'b000001000,
        S_UPD       = 9'b000010000,
        S_UPD_WAIT  = 9'b000100000,
        S_RSI       = 9'b001000000,
        S_RSI_WAIT  = 9'b010000000,
        S_EMIT      = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (sts.warmed)
                begin
                    cmd.mul    = 1'b1;
                    state_next = S_UPD;
                end
                else
                begin
                    cmd.warm_step = 1'b1;
                    state_next    = sts.seed_now ? S_SEED : S_EMIT;
                end
            end
            S_SEED:
            begin
                cmd.seed_go = 1'b1;
                state_next  = S_SEED_WAIT;
            end
            S_SEED_WAIT:
            begin
                if (sts.win_done)
                begin
                    cmd.seed_load = 1'b1;
                    state_next    = S_EMIT;
                end
            end
            S_UPD:
            begin
                cmd.upd_go = 1'b1;
                state_next = S_UPD_WAIT;
            end
            S_UPD_WAIT:
            begin
                if (sts.win_done)
                begin
                    cmd.upd_load = 1'b1;
                    state_next   = S_RSI;
                end
            end
            S_RSI:
            begin
                cmd.rsi_go = 1'b1;
                state_next = S_RSI_WAIT;
            end
            S_RSI_WAIT:
            begin
                if (sts.rsi_done)
                begin
                    cmd.rsi_load = 1'b1;
                    state_next   = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // output register must be free or emptying this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `WRSI_ASSERT_IMPLIES(a_win_done_in_wait, clk, rst_n, sts.win_done, (state_reg == S_SEED_WAIT) || (state_reg == S_UPD_WAIT), "window divider finished outside a wait state")
    `WRSI_ASSERT_IMPLIES(a_rsi_done_in_wait, clk, rst_n, sts.rsi_done, state_reg == S_RSI_WAIT, "rsi divider finished outside its wait state")
    `WRSI_ASSERT_IMPLIES(a_out_load_free, clk, rst_n, cmd.out_load, !out_valid_reg || out_ready, "result loaded over an untaken result")

endmodule

### rtl/core/wilder_rsi_stream_top.sv
// Streaming Wilder RSI over unsigned Q16.16 prices: one result per price request, with
// rsi_valid low and rsi_value zero for the first window+1 prices. A price during
// warm-up is accepted, summed and emitted; the seeding price also divides both sums by the
// window, and every later price divides both updated averages by the window and then the
// RSI ratio. The bit-serial dividers take QB steps, QB = max(48, PRICE_BITS+8), for the
// averages and 23 steps for the RSI ratio. A finished result waits in the output register
// while the next price is already taken. The user writes window_length through the cfg
// channel only while no request is in flight; the block itself does not enforce this.
// depends on wrsi_pkg, wrsi_if, wrsi_ctrl and wrsi_datapath
module wilder_rsi_stream_top import wrsi_pkg::*; #(
    parameter int PRICE_BITS = 32,
    parameter int WINDOW_MAX = 255
) (
    input  logic           clk,
    input  logic           rst_n,
    wrsi_price_if.sink     prices,
    wrsi_result_if.source  results,
    wrsi_cfg_if.sink       cfg
);

    wrsi_cmd_t cmd;
    wrsi_sts_t sts;

    assign cfg.ready = 1'b1;

    wrsi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prices.valid),
        .in_ready  (prices.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    wrsi_datapath #(
        .PRICE_BITS (PRICE_BITS),
        .WINDOW_MAX (WINDOW_MAX)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .price     (prices.price),
        .cfg_wr    (cfg.valid),
        .cfg_data  (cfg.window_length),
        .cmd       (cmd),
        .sts       (sts),
        .rsi_value (results.rsi_value),
        .rsi_valid (results.rsi_valid)
    );

endmodule
